/* rtl/stac_pkg.sv */
package stac_pkg;

   // Field widths of the item and result words.
   localparam int COORD_W     = 16;
   localparam int VALUE_W     = 32;
   localparam int TOTAL_W     = 6;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_FIRST  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_SECOND = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_SECOND = 2'd3;

   // Defaults of the top-level parameters.
   localparam int DEF_TABLE_DEPTH = 32;
   localparam int DEF_COORD_BITS  = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_START,
      ST_EMIT
   } stac_state_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic [VALUE_W-1:0] out_value;
      logic [TOTAL_W-1:0] entry_total;
      logic               last_result;
      logic               dims_mismatch;
      logic               table_overflow;
   } rsp_word_type;

   // Address width of the table; never below one bit.
   function automatic int idx_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Stored bits of one coordinate.
   function automatic int key_width(input int bits);
      return (bits < COORD_W) ? bits : COORD_W;
   endfunction

endpackage

/* rtl/stac_if.sv */
interface stac_req_if;
   import stac_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COORD_W-1:0]        row_index;
   logic [COORD_W-1:0]        col_index;
   logic signed [VALUE_W-1:0] entry_value;
   logic                      final_triplet;

   modport source (
      output valid, row_index, col_index, entry_value, final_triplet,
      input  ready
   );
   modport sink (
      input  valid, row_index, col_index, entry_value, final_triplet,
      output ready
   );
endinterface

interface stac_rsp_if;
   import stac_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COORD_W-1:0]        out_row;
   logic [COORD_W-1:0]        out_col;
   logic signed [VALUE_W-1:0] out_value;
   logic [TOTAL_W-1:0]        entry_total;
   logic                      last_result;
   logic                      dims_mismatch;
   logic                      table_overflow;

   modport source (
      output valid, out_row, out_col, out_value, entry_total, last_result,
             dims_mismatch, table_overflow,
      input  ready
   );
   modport sink (
      input  valid, out_row, out_col, out_value, entry_total, last_result,
             dims_mismatch, table_overflow,
      output ready
   );
endinterface

/* rtl/sparse_triplet_accumulate_core.sv */
// Sparse triplet accumulator: coordinate-format addition of two sparse matrices.
//
// req_port carries one (row, column, value) triplet per word, all triplets of
// the first matrix followed by those of the second; final_triplet marks the
// last one. The user must write the four dimension registers via csr_* only
// while the block is idle; the block itself does not enforce it. Each triplet
// is searched against the coordinate table, one stored entry per cycle through
// the single read port of the table memory; a match adds the value into that
// entry, a miss appends it, or sets the overflow flag when the table is full.
// req_port.ready is low while an item is searched. Non-final triplets give no
// result. After the final triplet it passes through a turnaround state and then
// emits one rsp_port word per table entry in order of first appearance, each
// carrying entry_total, with last_result on the final one; if the dimension
// registers disagree it emits a single dims_mismatch word instead.
// Results leave through an output register: a stalled receiver holds the
// sequencer on the current entry, and the block takes the next triplet while
// the last result still waits. Reset empties the table, clears the overflow
// flag and zeroes the dimension registers; no clearing pass is needed.
module sparse_triplet_accumulate_core #(
   parameter int TABLE_DEPTH = stac_pkg::DEF_TABLE_DEPTH,
   parameter int COORD_BITS  = stac_pkg::DEF_COORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   stac_req_if.sink                            req_port,
   stac_rsp_if.source                          rsp_port,
   input  logic                                csr_wr_en,
   input  logic [stac_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stac_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import stac_pkg::*;

   localparam int KEY_W = key_width(COORD_BITS);
   localparam int IDX_W = idx_width(TABLE_DEPTH);

   // dimension registers
   logic [CSR_DATA_W-1:0] rows_first_ff, rows_first_in;
   logic [CSR_DATA_W-1:0] cols_first_ff, cols_first_in;
   logic [CSR_DATA_W-1:0] rows_second_ff, rows_second_in;
   logic [CSR_DATA_W-1:0] cols_second_ff, cols_second_in;
   logic                  dims_match;

   // table port between sequencer and memory
   logic                  wr_coord_en;
   logic                  wr_value_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [2*KEY_W-1:0]    wr_coord;
   logic [VALUE_W-1:0]    wr_value;
   logic [IDX_W-1:0]      rd_addr;
   logic [2*KEY_W-1:0]    rd_coord;
   logic [VALUE_W-1:0]    rd_value;

   // result path
   logic                  emit_valid;
   logic                  emit_ready;
   rsp_word_type          emit_word;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   // Decode configuration writes; hold registers otherwise.
   always_comb begin
      rows_first_in  = rows_first_ff;
      cols_first_in  = cols_first_ff;
      rows_second_in = rows_second_ff;
      cols_second_in = cols_second_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_FIRST:  rows_first_in  = csr_wdata;
            CSR_COLS_FIRST:  cols_first_in  = csr_wdata;
            CSR_ROWS_SECOND: rows_second_in = csr_wdata;
            CSR_COLS_SECOND: cols_second_in = csr_wdata;
            default:         rows_first_in  = rows_first_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_first_ff  <= '0;
         cols_first_ff  <= '0;
         rows_second_ff <= '0;
         cols_second_ff <= '0;
      end else begin
         rows_first_ff  <= rows_first_in;
         cols_first_ff  <= cols_first_in;
         rows_second_ff <= rows_second_in;
         cols_second_ff <= cols_second_in;
      end
   end

   assign dims_match = (rows_first_ff == rows_second_ff) &&
                       (cols_first_ff == cols_second_ff);

   stac_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_port.valid),
      .in_ready    (req_port.ready),
      .in_row      (req_port.row_index),
      .in_col      (req_port.col_index),
      .in_value    (req_port.entry_value),
      .in_final    (req_port.final_triplet),
      .dims_match  (dims_match),
      .wr_coord_en (wr_coord_en),
      .wr_value_en (wr_value_en),
      .wr_addr     (wr_addr),
      .wr_coord    (wr_coord),
      .wr_value    (wr_value),
      .rd_addr     (rd_addr),
      .rd_coord    (rd_coord),
      .rd_value    (rd_value),
      .emit_valid  (emit_valid),
      .emit_ready  (emit_ready),
      .emit_word   (emit_word)
   );

   stac_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_table (
      .clock       (clock),
      .wr_coord_en (wr_coord_en),
      .wr_value_en (wr_value_en),
      .wr_addr     (wr_addr),
      .wr_coord    (wr_coord),
      .wr_value    (wr_value),
      .rd_addr     (rd_addr),
      .rd_coord    (rd_coord),
      .rd_value    (rd_value)
   );

   // Output register: load a new word when empty or when the held word
   // leaves in this cycle; otherwise hold.
   assign emit_ready = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (emit_ready) begin
         rsp_valid_in = emit_valid;
         if (emit_valid) begin
            rsp_word_in = emit_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.out_row        = rsp_word_ff.out_row;
   assign rsp_port.out_col        = rsp_word_ff.out_col;
   assign rsp_port.out_value      = rsp_word_ff.out_value;
   assign rsp_port.entry_total    = rsp_word_ff.entry_total;
   assign rsp_port.last_result    = rsp_word_ff.last_result;
   assign rsp_port.dims_mismatch  = rsp_word_ff.dims_mismatch;
   assign rsp_port.table_overflow = rsp_word_ff.table_overflow;

endmodule

/* rtl/stac_table.sv */
module stac_table #(
   parameter int TABLE_DEPTH = stac_pkg::DEF_TABLE_DEPTH,
   parameter int COORD_BITS  = stac_pkg::DEF_COORD_BITS
) (
   input  logic                                            clock,
   input  logic                                            wr_coord_en,
   input  logic                                            wr_value_en,
   input  logic [stac_pkg::idx_width(TABLE_DEPTH)-1:0]     wr_addr,
   input  logic [2*stac_pkg::key_width(COORD_BITS)-1:0]    wr_coord,
   input  logic [stac_pkg::VALUE_W-1:0]                    wr_value,
   input  logic [stac_pkg::idx_width(TABLE_DEPTH)-1:0]     rd_addr,
   output logic [2*stac_pkg::key_width(COORD_BITS)-1:0]    rd_coord,
   output logic [stac_pkg::VALUE_W-1:0]                    rd_value
);
   import stac_pkg::*;

   localparam int KEY_W = key_width(COORD_BITS);

   logic [2*KEY_W-1:0] coord_mem_ff [TABLE_DEPTH];
   logic [VALUE_W-1:0] value_mem_ff [TABLE_DEPTH];
   logic [2*KEY_W-1:0] rd_coord_ff;
   logic [VALUE_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_coord_en) begin
         coord_mem_ff[wr_addr] <= wr_coord;
      end
      if (wr_value_en) begin
         value_mem_ff[wr_addr] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_coord_ff <= coord_mem_ff[rd_addr];
      rd_value_ff <= value_mem_ff[rd_addr];
   end

   assign rd_coord = rd_coord_ff;
   assign rd_value = rd_value_ff;

endmodule

/* rtl/stac_ctrl.sv */
module stac_ctrl #(
   parameter int TABLE_DEPTH = stac_pkg::DEF_TABLE_DEPTH,
   parameter int COORD_BITS  = stac_pkg::DEF_COORD_BITS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   // input words
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  logic [stac_pkg::COORD_W-1:0]                    in_row,
   input  logic [stac_pkg::COORD_W-1:0]                    in_col,
   input  logic [stac_pkg::VALUE_W-1:0]                    in_value,
   input  logic                                            in_final,
   input  logic                                            dims_match,
   // table port
   output logic                                            wr_coord_en,
   output logic                                            wr_value_en,
   output logic [stac_pkg::idx_width(TABLE_DEPTH)-1:0]     wr_addr,
   output logic [2*stac_pkg::key_width(COORD_BITS)-1:0]    wr_coord,
   output logic [stac_pkg::VALUE_W-1:0]                    wr_value,
   output logic [stac_pkg::idx_width(TABLE_DEPTH)-1:0]     rd_addr,
   input  logic [2*stac_pkg::key_width(COORD_BITS)-1:0]    rd_coord,
   input  logic [stac_pkg::VALUE_W-1:0]                    rd_value,
   // result words
   output logic                                            emit_valid,
   input  logic                                            emit_ready,
   output stac_pkg::rsp_word_type                          emit_word
);
   import stac_pkg::*;

   localparam int KEY_W = key_width(COORD_BITS);
   localparam int IDX_W = idx_width(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   stac_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [2*KEY_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               fin_ff, fin_in;

   logic               table_empty;
   logic               table_full;
   logic [CNT_W-1:0]   addr_next_cnt;
   logic               at_last;
   logic               key_hit;
   logic               scan_done;
   logic               emit_last;
   logic [VALUE_W-1:0] value_sum;

   assign table_empty   = (count_ff == '0);
   assign table_full    = (count_ff == DEPTH_CNT);
   assign addr_next_cnt = CNT_W'(addr_ff) + CNT_W'(1);
   assign at_last       = table_empty || (addr_next_cnt == count_ff);
   assign key_hit       = !table_empty && (rd_coord == key_ff);
   assign scan_done     = key_hit || at_last;
   assign emit_last     = !dims_match || at_last;
   // accumulate adder, wraps at 32 bits
   assign value_sum     = rd_value + value_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = fin_ff ? ST_START : ST_IDLE;
            end
         end
         ST_START: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_ready && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      in_ready    = 1'b0;
      addr_in     = addr_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      fin_in      = fin_ff;
      wr_coord_en = 1'b0;
      wr_value_en = 1'b0;
      wr_addr     = addr_ff;
      wr_coord    = key_ff;
      wr_value    = value_sum;
      emit_valid  = 1'b0;
      emit_word   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               key_in   = {in_row[KEY_W-1:0], in_col[KEY_W-1:0]};
               value_in = in_value;
               fin_in   = in_final;
               addr_in  = '0;
            end
         end
         ST_SCAN: begin
            if (key_hit) begin
               wr_value_en = 1'b1;
            end else if (at_last) begin
               if (!table_full) begin
                  wr_coord_en = 1'b1;
                  wr_value_en = 1'b1;
                  wr_addr     = count_ff[IDX_W-1:0];
                  wr_value    = value_ff;
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_START: begin
            addr_in = '0;
         end
         ST_EMIT: begin
            emit_valid                = 1'b1;
            emit_word.last_result     = emit_last;
            emit_word.table_overflow  = ovf_ff;
            if (!dims_match) begin
               emit_word.dims_mismatch = 1'b1;
            end else if (!table_empty) begin
               emit_word.out_row     = COORD_W'(rd_coord[2*KEY_W-1:KEY_W]);
               emit_word.out_col     = COORD_W'(rd_coord[KEY_W-1:0]);
               emit_word.out_value   = rd_value;
               emit_word.entry_total = TOTAL_W'(count_ff);
            end
            if (emit_ready) begin
               addr_in = addr_ff + IDX_W'(1);
               if (emit_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   assign rd_addr = addr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      fin_ff   <= fin_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond table depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !table_empty |-> addr_next_cnt <= count_ff)
      else $error("search address past the filled entries");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      wr_coord_en |-> !table_full && (state_ff == ST_SCAN))
      else $error("append into a full table");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      emit_valid && emit_ready && emit_last
      |=> (state_ff == ST_IDLE) && (count_ff == '0) && !ovf_ff)
      else $error("run state not cleared after the last result");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import stac_pkg::*;

   localparam int TABLE_DEPTH   = DEF_TABLE_DEPTH;
   localparam int COORD_BITS    = DEF_COORD_BITS;
   localparam int RANDOM_ITEMS  = 190;
   // Worst item scan plus turnaround, with margin, before touching the CSRs.
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
   localparam int DRAIN_LIMIT   = 200000;
   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

   // One triplet word as the sender sees it.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [VALUE_W-1:0] value;
      logic               fin;
   } triplet_type;

   // One row of the directed stimulus: either a CSR write or a triplet,
   // optionally with its single result typed in by hand.
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      triplet_type            word;
      bit                     typed;
      rsp_word_type           result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   stac_req_if req_bus ();
   stac_rsp_if rsp_bus ();

   sparse_triplet_accumulate_core #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Shadow of the block: coordinate table, running sums, fill level,
   // the dropped-coordinate flag and the four dimension registers.
   logic [2*COORD_W-1:0]  coord_keys [TABLE_DEPTH];
   logic [VALUE_W-1:0]    entry_sums [TABLE_DEPTH];
   int                    entry_fill    = 0;
   bit                    overflow_flag = 1'b0;
   logic [CSR_DATA_W-1:0] dim_regs [4] = '{default: '0};

   rsp_word_type pending_entries[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   bit           calm = 1'b0;   // suppress all idling on both sides

   function automatic rsp_word_type make_result(
      input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
      input logic [VALUE_W-1:0] val, input logic [TOTAL_W-1:0] total,
      input logic last, input logic mism, input logic ovf);
      rsp_word_type w;
      w.out_row        = row;
      w.out_col        = col;
      w.out_value      = val;
      w.entry_total    = total;
      w.last_result    = last;
      w.dims_mismatch  = mism;
      w.table_overflow = ovf;
      return w;
   endfunction

   // Merge one triplet into the shadow table; on the final triplet produce the
   // result words of the run and start a fresh run.
   function automatic void accumulate_triplet(input triplet_type t, ref rsp_word_type words[$]);
      logic [2*COORD_W-1:0] key;
      bit                   hit;
      bit                   dims_differ;
      key = {t.row & COORD_MASK, t.col & COORD_MASK};
      hit = 1'b0;
      words.delete();
      // Earliest matching entry takes the value, with 32-bit wrap.
      for (int i = 0; i < entry_fill; i++) begin
         if (!hit && coord_keys[i] == key) begin
            entry_sums[i] = entry_sums[i] + t.value;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (entry_fill < TABLE_DEPTH) begin
            coord_keys[entry_fill] = key;
            entry_sums[entry_fill] = t.value;
            entry_fill++;
         end else begin
            // Table full: drop the new coordinate, remember it for the run.
            overflow_flag = 1'b1;
         end
      end
      if (!t.fin) return;
      dims_differ = (dim_regs[CSR_ROWS_FIRST] != dim_regs[CSR_ROWS_SECOND]) ||
                    (dim_regs[CSR_COLS_FIRST] != dim_regs[CSR_COLS_SECOND]);
      if (dims_differ) begin
         words.push_back(make_result('0, '0, '0, '0, 1'b1, 1'b1, overflow_flag));
      end else if (entry_fill == 0) begin
         words.push_back(make_result('0, '0, '0, '0, 1'b1, 1'b0, overflow_flag));
      end else begin
         for (int i = 0; i < entry_fill; i++) begin
            words.push_back(make_result(coord_keys[i][2*COORD_W-1:COORD_W],
                                        coord_keys[i][COORD_W-1:0], entry_sums[i],
                                        TOTAL_W'(entry_fill), i == entry_fill - 1,
                                        1'b0, overflow_flag));
         end
      end
      entry_fill    = 0;
      overflow_flag = 1'b0;
   endfunction

   function automatic void add_triplet(input logic [COORD_W-1:0] row,
      input logic [COORD_W-1:0] col, input logic [VALUE_W-1:0] val, input logic fin);
      stim_row_type r;
      r = '{default: '0};
      r.word = '{row: row, col: col, value: val, fin: fin};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_typed(input logic [COORD_W-1:0] row,
      input logic [COORD_W-1:0] col, input logic [VALUE_W-1:0] val, input logic fin,
      input rsp_word_type result);
      stim_row_type r;
      r = '{default: '0};
      r.word   = '{row: row, col: col, value: val, fin: fin};
      r.typed  = 1'b1;
      r.result = result;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] idx,
      input logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r = '{default: '0};
      r.is_csr  = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      directed_rows.push_back(r);
   endfunction

   // Draw one random triplet. Repeats of stored coordinates come back often,
   // sometimes with the exact negation of the running sum so it lands on zero.
   function automatic triplet_type draw_triplet(input bit wide, input bit fin);
      triplet_type t;
      int unsigned pick;
      int unsigned repeat_pct;
      bit          valued;
      valued     = 1'b0;
      repeat_pct = wide ? 10 : 35;
      t.fin      = fin;
      if (entry_fill > 0 && $urandom_range(0, 99) < repeat_pct) begin
         pick  = $urandom_range(0, entry_fill - 1);
         t.row = coord_keys[pick][2*COORD_W-1:COORD_W];
         t.col = coord_keys[pick][COORD_W-1:0];
         if ($urandom_range(0, 3) == 0) begin
            t.value = -entry_sums[pick];
            valued  = 1'b1;
         end
      end else if (wide || $urandom_range(0, 3) == 0) begin
         t.row = COORD_W'($urandom);
         t.col = COORD_W'($urandom);
      end else begin
         t.row = COORD_W'($urandom_range(0, 5));
         t.col = COORD_W'($urandom_range(0, 5));
      end
      if (!valued) begin
         case ($urandom_range(0, 9))
            0:       t.value = 32'h8000_0000;
            1:       t.value = 32'h7FFF_FFFF;
            2, 3, 4: t.value = VALUE_W'($urandom_range(0, 20)) - 32'd10;
            default: t.value = $urandom;
         endcase
      end
      return t;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Present one word and hold it until the block takes it. Idle before it at
   // random unless the calm stretch is on.
   task automatic send_triplet(input triplet_type t);
      int unsigned gap;
      if (!calm && $urandom_range(0, 99) < 33) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.row_index     <= t.row;
      req_bus.col_index     <= t.col;
      req_bus.entry_value   <= t.value;
      req_bus.final_triplet <= t.fin;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Drop valid, wait for every expected word, then let a worst-case scan pass.
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_entries.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
      input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      dim_regs[idx] = val;
   endtask

   // Send one word, predict it, and queue either the hand-typed word or the
   // predicted ones.
   task automatic issue_triplet(input triplet_type t, input bit typed,
      input rsp_word_type result);
      rsp_word_type words[$];
      send_triplet(t);
      accumulate_triplet(t, words);
      if (typed) begin
         pending_entries.push_back(result);
      end else begin
         foreach (words[i]) pending_entries.push_back(words[i]);
      end
   endtask

   // Receiver: random back-pressure, with an occasional long stall.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(8, 24)) @(posedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 33);
         end
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_entries.size() == 0) begin
            $display("%0t: unexpected result word, row %h col %h value %h", $time,
                     rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_value);
            mismatch_count++;
         end else begin
            want = pending_entries.pop_front();
            check_field("out_row", 32'(want.out_row), 32'(rsp_bus.out_row));
            check_field("out_col", 32'(want.out_col), 32'(rsp_bus.out_col));
            check_field("out_value", want.out_value, rsp_bus.out_value);
            check_field("entry_total", 32'(want.entry_total), 32'(rsp_bus.entry_total));
            check_field("last_result", 32'(want.last_result), 32'(rsp_bus.last_result));
            check_field("dims_mismatch", 32'(want.dims_mismatch), 32'(rsp_bus.dims_mismatch));
            check_field("table_overflow", 32'(want.table_overflow),
                        32'(rsp_bus.table_overflow));
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(2_000_000);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      triplet_type            word;
      logic [CSR_DATA_W-1:0]  rf, cf, rs, cs, delta;
      int                     random_items;
      int                     run_index;
      int                     run_len;
      bit                     long_run;
      rsp_word_type           none;

      random_items = 0;
      run_index    = 0;
      none         = '0;

      req_bus.valid         <= 1'b0;
      req_bus.row_index     <= '0;
      req_bus.col_index     <= '0;
      req_bus.entry_value   <= '0;
      req_bus.final_triplet <= 1'b0;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_ROWS_FIRST;
      csr_wdata             <= '0;

      // Directed part. Dimensions reset to zero, so they match at first.
      add_typed(16'h0000, 16'h0000, 32'h0000_0000, 1'b1,
                make_result(16'h0000, 16'h0000, 32'h0000_0000, 6'd1, 1'b1, 1'b0, 1'b0));
      add_typed(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1,
                make_result(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 6'd1, 1'b1, 1'b0, 1'b0));
      // Repeats wrap through the minimum to a zero sum that a later triplet raises;
      // the second matrix revisits an entry of the first.
      add_triplet(16'h0001, 16'h0002, 32'h8000_0000, 1'b0);
      add_triplet(16'h0001, 16'h0002, 32'h8000_0000, 1'b0);
      add_triplet(16'h0003, 16'h0004, 32'hFFFF_FFFF, 1'b0);
      add_triplet(16'h0001, 16'h0002, 32'h0000_0005, 1'b0);
      add_triplet(16'hFFFF, 16'h0000, 32'h0000_0001, 1'b0);
      add_triplet(16'h0000, 16'hFFFF, 32'h8000_0000, 1'b1);
      // Row counts disagree: one error word only.
      add_csr(CSR_ROWS_FIRST, 16'hFFFF);
      add_typed(16'h0005, 16'h0005, 32'h0000_0001, 1'b1,
                make_result('0, '0, '0, '0, 1'b1, 1'b1, 1'b0));
      // All dimensions at their maximum: match again.
      add_csr(CSR_ROWS_SECOND, 16'hFFFF);
      add_csr(CSR_COLS_FIRST, 16'hFFFF);
      add_csr(CSR_COLS_SECOND, 16'hFFFF);
      add_triplet(16'hAAAA, 16'h5555, 32'h1234_5678, 1'b0);
      add_triplet(16'h5555, 16'hAAAA, 32'hEDCB_A988, 1'b0);
      add_triplet(16'hAAAA, 16'h5555, 32'hEDCB_A988, 1'b1);
      // Column counts disagree only.
      add_csr(CSR_COLS_SECOND, 16'h0000);
      add_triplet(16'h0009, 16'h0009, 32'hFFFF_FFFF, 1'b0);
      add_typed(16'h0009, 16'h0009, 32'h0000_0001, 1'b1,
                make_result('0, '0, '0, '0, 1'b1, 1'b1, 1'b0));
      add_csr(CSR_COLS_SECOND, 16'hFFFF);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle_block();
            csr_write(directed_rows[i].csr_idx, directed_rows[i].csr_val);
            csr_wr_en <= 1'b0;
         end else begin
            issue_triplet(directed_rows[i].word, directed_rows[i].typed,
                          directed_rows[i].result);
         end
      end

      // Random part: runs of triplets, each closed by a final word. Long runs
      // overfill the table; the first random run is always one of them.
      while (random_items < RANDOM_ITEMS) begin
         run_index++;
         calm = (random_items >= 70 && random_items < 130);
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  rf = '0;
                  cf = '0;
               end
               1: begin
                  rf = '1;
                  cf = '1;
               end
               default: begin
                  rf = CSR_DATA_W'($urandom);
                  cf = CSR_DATA_W'($urandom);
               end
            endcase
            rs = rf;
            cs = cf;
            // Break the match now and then on one register.
            if ($urandom_range(0, 2) == 0) begin
               delta = CSR_DATA_W'($urandom_range(1, 65535));
               case ($urandom_range(0, 3))
                  0:       rf = rf ^ delta;
                  1:       cf = cf ^ delta;
                  2:       rs = rs ^ delta;
                  default: cs = cs ^ delta;
               endcase
            end
            settle_block();
            csr_write(CSR_ROWS_FIRST, rf);
            csr_write(CSR_COLS_FIRST, cf);
            csr_write(CSR_ROWS_SECOND, rs);
            csr_write(CSR_COLS_SECOND, cs);
            csr_wr_en <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            // Hold the sender until the previous run has fully drained.
            settle_block();
         end
         long_run = (run_index == 1) || ($urandom_range(0, 5) == 0);
         run_len  = long_run ? $urandom_range(38, 48) : $urandom_range(1, 14);
         for (int k = 0; k < run_len; k++) begin
            word = draw_triplet(long_run, k == run_len - 1);
            issue_triplet(word, 1'b0, none);
            random_items++;
         end
      end
      calm = 1'b0;

      // Drain: wait for the outstanding words, then a full scan's worth more.
      req_bus.valid <= 1'b0;
      for (int k = 0; k < DRAIN_LIMIT && pending_entries.size() != 0; k++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_entries.size() != 0) begin
         $display("%0t: %0d expected result words never arrived", $time,
                  pending_entries.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
